// ===== rtl/string_escape_decoder_assert.svh =====
// assertion macros shared by the string escape decoder modules
`ifndef STRING_ESCAPE_DECODER_ASSERT_SVH
`define STRING_ESCAPE_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sed_pkg.sv =====
// types, constants and character helpers of the string escape decoder
`default_nettype none

package sed_pkg;

  // octal run length and its counter form
  localparam int MAX_OCTAL_DIGITS = 3;
  localparam logic [1:0] OCT_LIMIT = 2'(MAX_OCTAL_DIGITS);

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  // characters that steer decoding
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_QUOTE     = 8'h22;
  localparam logic [7:0] CHR_X         = 8'h78;
  localparam logic [7:0] CHR_A         = 8'h61;
  localparam logic [7:0] CHR_B         = 8'h62;
  localparam logic [7:0] CHR_F         = 8'h66;
  localparam logic [7:0] CHR_R         = 8'h72;
  localparam logic [7:0] CHR_N         = 8'h6E;
  localparam logic [7:0] CHR_T         = 8'h74;
  localparam logic [7:0] CHR_V         = 8'h76;

  // control codes produced by the named escapes
  localparam logic [7:0] CODE_BEL = 8'd7;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_HT  = 8'd9;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_VT  = 8'd11;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_CR  = 8'd13;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESCAPE = 4'b0010,
    MODE_HEX    = 4'b0100,
    MODE_OCTAL  = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] pending;
    logic [1:0] octal_count;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       run_last;
    logic       string_done;
    logic       bad;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } named_esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  localparam dec_state_t STATE_RESET = '{mode: MODE_NORMAL, pending: 8'd0, octal_count: 2'd0};

  // single-character escapes
  function automatic named_esc_t named_escape(input logic [7:0] c);
    named_esc_t r;
    r.hit = 1'b1;
    case (c)
      CHR_A:         r.code = CODE_BEL;
      CHR_B:         r.code = CODE_BS;
      CHR_F:         r.code = CODE_FF;
      CHR_R:         r.code = CODE_CR;
      CHR_N:         r.code = CODE_LF;
      CHR_T:         r.code = CODE_HT;
      CHR_V:         r.code = CODE_VT;
      CHR_QUOTE:     r.code = CHR_QUOTE;
      CHR_BACKSLASH: r.code = CHR_BACKSLASH;
      default: begin
        r.hit  = 1'b0;
        r.code = 8'd0;
      end
    endcase
    return r;
  endfunction

  // hex digit value, either letter case
  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.ok  = 1'b1;
      r.val = 4'(c[3:0] + 4'd9);
    end
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return c[7:3] == 5'b00110;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sed_decode.sv =====
// decode logic: one character against the mode state, up to two results
`default_nettype none

module sed_decode (
  input  sed_pkg::dec_state_t   state_cur,
  input  logic [7:0]            char_in,
  input  logic                  string_end,
  output sed_pkg::dec_state_t   state_next,
  output sed_pkg::result_pair_t results
);
  import sed_pkg::*;

  dec_state_t st;
  logic       as_normal;
  logic [1:0] n;
  logic [7:0] byte_v [2];
  logic       bad_v  [2];
  named_esc_t esc;
  hex_digit_t hd;

  assign esc = named_escape(char_in);
  assign hd  = hex_digit(char_in);

  // mode machine, results collected in order
  always_comb begin
    st        = state_cur;
    as_normal = 1'b0;
    n         = 2'd0;
    byte_v[0] = 8'd0;
    byte_v[1] = 8'd0;
    bad_v[0]  = 1'b0;
    bad_v[1]  = 1'b0;

    case (state_cur.mode)
      MODE_NORMAL: begin
        as_normal = 1'b1;
      end
      MODE_ESCAPE: begin
        st.mode = MODE_NORMAL;
        if (esc.hit) begin
          byte_v[n[0]] = esc.code;
          n = n + 2'd1;
        end else if (char_in == CHR_X) begin
          st.mode    = MODE_HEX;
          st.pending = 8'd0;
        end else if (is_octal(char_in)) begin
          st.pending     = {5'd0, char_in[2:0]};
          st.octal_count = 2'd1;
          if (2'd1 >= OCT_LIMIT) begin
            byte_v[n[0]]   = st.pending;
            n              = n + 2'd1;
            st.octal_count = 2'd0;
          end else begin
            st.mode = MODE_OCTAL;
          end
        end else begin
          bad_v[n[0]] = 1'b1;
          n = n + 2'd1;
        end
      end
      MODE_HEX: begin
        if (hd.ok) begin
          st.pending = {state_cur.pending[3:0], hd.val};
        end else begin
          byte_v[n[0]] = state_cur.pending;
          n            = n + 2'd1;
          st.mode      = MODE_NORMAL;
          as_normal    = 1'b1;
        end
      end
      MODE_OCTAL: begin
        if (is_octal(char_in)) begin
          st.pending     = {state_cur.pending[4:0], char_in[2:0]};
          st.octal_count = state_cur.octal_count + 2'd1;
          if (st.octal_count >= OCT_LIMIT) begin
            byte_v[n[0]]   = st.pending;
            n              = n + 2'd1;
            st.mode        = MODE_NORMAL;
            st.octal_count = 2'd0;
          end
        end else begin
          byte_v[n[0]]   = state_cur.pending;
          n              = n + 2'd1;
          st.mode        = MODE_NORMAL;
          st.octal_count = 2'd0;
          as_normal      = 1'b1;
        end
      end
      default: begin
        as_normal = 1'b1;
      end
    endcase

    // plain character, or the terminator of a digit run
    if (as_normal) begin
      if (char_in == CHR_BACKSLASH) begin
        st.mode = MODE_ESCAPE;
      end else if (n < 2'd2) begin
        byte_v[n[0]] = char_in;
        n = n + 2'd1;
      end
    end

    // string end flushes a dangling escape or a pending run
    if (string_end) begin
      if (st.mode == MODE_ESCAPE) begin
        if (n < 2'd2) begin
          byte_v[n[0]] = 8'd0;
          bad_v[n[0]]  = 1'b1;
          n = n + 2'd1;
        end
      end else if (st.mode == MODE_HEX || st.mode == MODE_OCTAL) begin
        if (n < 2'd2) begin
          byte_v[n[0]] = st.pending;
          n = n + 2'd1;
        end
      end
      st = STATE_RESET;
    end
  end

  // tag results with their position in the run
  always_comb begin
    state_next                  = st;
    results.count               = n;
    results.first.byte_val      = byte_v[0];
    results.first.bad           = bad_v[0];
    results.first.run_last      = (n == 2'd1);
    results.first.string_done   = (n == 2'd1) && string_end;
    results.second.byte_val     = byte_v[1];
    results.second.bad          = bad_v[1];
    results.second.run_last     = 1'b1;
    results.second.string_done  = string_end;
  end

endmodule

`default_nettype wire

// ===== rtl/sed_result_fifo.sv =====
// result queue: takes up to two results a cycle, hands out one a cycle while out_ready is high
`default_nettype none

module sed_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  sed_pkg::result_t  push_first,
  input  sed_pkg::result_t  push_second,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output sed_pkg::result_t  head
);
  import sed_pkg::*;

  `include "string_escape_decoder_assert.svh"

  result_t              slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic [FIFO_CW-1:0]   count_next;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign head      = slots[rd_ptr];
  assign room      = (count <= FIFO_CW'(FIFO_DEPTH - 2));

  // occupancy after this cycle's pushes and pop
  always_comb begin
    count_next = count + FIFO_CW'(push_count) - FIFO_CW'(pop);
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_count);
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      count  <= count_next;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr + FIFO_AW'(1)] <= push_second;
    end
  end

  `SED_ASSERT_NOW(a_fifo_bound, 1'b1, count <= FIFO_CW'(FIFO_DEPTH), "result queue overfilled")
  `SED_ASSERT_NOW(a_push_fits, push_count != 2'd0,
    FIFO_CW'(push_count) <= FIFO_CW'(FIFO_DEPTH) - count, "push into a full result queue")
  `SED_ASSERT_NOW(a_ptr_gap, 1'b1, FIFO_AW'(wr_ptr - rd_ptr) == count[FIFO_AW-1:0],
    "queue pointers disagree with occupancy")

endmodule

`default_nettype wire

// ===== rtl/string_escape_decoder.sv =====
// top level of the string escape decoder: request register, mode state, result queue
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid, in_ready  | char_in, string_end
//   out     | out_valid, out_ready| byte_out, run_last, string_done, bad_escape
//
// one request per cycle while the queue has room; a request that decodes to two bytes
// holds the output port for both, so the sustained rate is one byte per cycle at the port
// while out_ready stays high. the first result passes the request register, then the queue.
// mode, pending value and octal count update in the cycle the request decodes.
// synchronous reset returns to normal mode and empties the queue.
// once more than two results wait in the queue the request register holds
// and in_ready drops.
`default_nettype none

module string_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       string_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_out,
  output logic       run_last,
  output logic       string_done,
  output logic       bad_escape
);
  import sed_pkg::*;

  `include "string_escape_decoder_assert.svh"

  logic         req_full;
  logic [7:0]   char_q;
  logic         end_q;
  logic         take;
  logic         room;
  dec_state_t   state;
  dec_state_t   state_next;
  result_pair_t results;
  result_t      head;

  assign take     = req_full && room;
  assign in_ready = !req_full || take;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_full <= 1'b1;
    end else if (take) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q <= char_in;
      end_q  <= string_end;
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (take) begin
      state <= state_next;
    end
  end

  sed_decode u_decode (
    .state_cur  (state),
    .char_in    (char_q),
    .string_end (end_q),
    .state_next (state_next),
    .results    (results)
  );

  sed_result_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_count  (take ? results.count : 2'd0),
    .push_first  (results.first),
    .push_second (results.second),
    .room        (room),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .head        (head)
  );

  // result fields
  assign byte_out    = head.byte_val;
  assign run_last    = head.run_last;
  assign string_done = head.string_done;
  assign bad_escape  = head.bad;

  `SED_ASSERT_NEXT(a_end_resets, take && end_q,
    state.mode == MODE_NORMAL && state.pending == 8'd0 && state.octal_count == 2'd0,
    "state not cleared after string end")
  `SED_ASSERT_NOW(a_end_emits, take && end_q, results.count != 2'd0,
    "string end produced no byte")
  `SED_ASSERT_NOW(a_oct_bound, 1'b1, state.octal_count < OCT_LIMIT,
    "octal digit count past its limit")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the string escape decoder: directed and random strings checked against a decode predictor
`default_nettype none

module tb_top;
  import sed_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_CHARS = 600;
  localparam int IDLE_PCT = 16;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SEVEN   = 8'h37;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_in = 8'd0;
  logic       string_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] byte_out;
  logic       run_last;
  logic       string_done;
  logic       bad_escape;

  char_req_t char_q[$];
  char_req_t string_buf[$];
  result_t   decoded_q[$];
  int        chars_pushed = 0;
  int        chars_taken = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  // predictor state
  mode_t      dec_mode = MODE_NORMAL;
  logic [7:0] pend_val = 8'd0;
  logic [1:0] oct_cnt = 2'd0;

  logic quiet;
  assign quiet = (cycle_count >= 300) && (cycle_count < 700);

  string_escape_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_in     (char_in),
    .string_end  (string_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_out    (byte_out),
    .run_last    (run_last),
    .string_done (string_done),
    .bad_escape  (bad_escape)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic octal_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  // decode one character and queue the bytes it yields
  function automatic void decode_char(input logic [7:0] c, input logic fin);
    logic [8:0] res [2];
    int         n;
    logic       plain;
    logic       hit;
    logic [7:0] code;
    logic       hex_ok;
    logic [3:0] hex_val;
    result_t    r;
    n = 0;
    plain = 1'b0;
    hit = 1'b1;
    code = 8'd0;
    hex_ok = 1'b0;
    hex_val = 4'd0;
    case (dec_mode)
      MODE_NORMAL: plain = 1'b1;
      MODE_ESCAPE: begin
        dec_mode = MODE_NORMAL;
        case (c)
          CHR_A:         code = CODE_BEL;
          CHR_B:         code = CODE_BS;
          CHR_F:         code = CODE_FF;
          CHR_R:         code = CODE_CR;
          CHR_N:         code = CODE_LF;
          CHR_T:         code = CODE_HT;
          CHR_V:         code = CODE_VT;
          CHR_QUOTE:     code = CHR_QUOTE;
          CHR_BACKSLASH: code = CHR_BACKSLASH;
          default:       hit = 1'b0;
        endcase
        if (hit) begin
          res[n] = {1'b0, code};
          n++;
        end else if (c == CHR_X) begin
          dec_mode = MODE_HEX;
          pend_val = 8'd0;
        end else if (octal_digit(c)) begin
          pend_val = c - CH_ZERO;
          oct_cnt = 2'd1;
          if (oct_cnt >= OCT_LIMIT) begin
            res[n] = {1'b0, pend_val};
            n++;
            oct_cnt = 2'd0;
          end else begin
            dec_mode = MODE_OCTAL;
          end
        end else begin
          // unknown escape, character consumed
          res[n] = {1'b1, 8'd0};
          n++;
        end
      end
      MODE_HEX: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          hex_ok = 1'b1;
          hex_val = c[3:0];
        end else if (c >= CHR_A && c <= CHR_F) begin
          hex_ok = 1'b1;
          hex_val = 4'(c - CHR_A + 8'd10);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
          hex_ok = 1'b1;
          hex_val = 4'(c - CH_UPPER_A + 8'd10);
        end
        if (hex_ok) begin
          pend_val = {pend_val[3:0], hex_val};
        end else begin
          res[n] = {1'b0, pend_val};
          n++;
          dec_mode = MODE_NORMAL;
          plain = 1'b1;
        end
      end
      default: begin
        if (octal_digit(c)) begin
          pend_val = {pend_val[4:0], c[2:0]};
          oct_cnt = oct_cnt + 2'd1;
          if (oct_cnt >= OCT_LIMIT) begin
            res[n] = {1'b0, pend_val};
            n++;
            dec_mode = MODE_NORMAL;
            oct_cnt = 2'd0;
          end
        end else begin
          res[n] = {1'b0, pend_val};
          n++;
          dec_mode = MODE_NORMAL;
          oct_cnt = 2'd0;
          plain = 1'b1;
        end
      end
    endcase

    // terminator of a run, or an ordinary character
    if (plain) begin
      if (c == CHR_BACKSLASH) begin
        dec_mode = MODE_ESCAPE;
      end else begin
        res[n] = {1'b0, c};
        n++;
      end
    end

    // end of string flushes whatever is open
    if (fin) begin
      if (dec_mode == MODE_ESCAPE) begin
        res[n] = {1'b1, 8'd0};
        n++;
      end else if (dec_mode == MODE_HEX || dec_mode == MODE_OCTAL) begin
        res[n] = {1'b0, pend_val};
        n++;
      end
      dec_mode = MODE_NORMAL;
      pend_val = 8'd0;
      oct_cnt = 2'd0;
    end

    for (int k = 0; k < n; k++) begin
      r.byte_val = res[k][7:0];
      r.bad = res[k][8];
      r.run_last = (k == n - 1);
      r.string_done = (k == n - 1) && fin;
      decoded_q.push_back(r);
    end
  endfunction

  // request driver
  always @(posedge clk) begin : drive
    char_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (char_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = char_q.pop_front();
        in_valid <= 1'b1;
        char_in <= nxt.ch;
        string_end <= nxt.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted requests, check accepted bytes
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        decode_char(char_in, string_end);
        chars_taken++;
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected byte_out=%0h with nothing pending", byte_out);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          if (byte_out !== want.byte_val) begin
            $error("byte_out: expected %0h, got %0h", want.byte_val, byte_out);
            mismatch_count++;
          end
          if (run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, run_last);
            mismatch_count++;
          end
          if (string_done !== want.string_done) begin
            $error("string_done: expected %0b, got %0b", want.string_done, string_done);
            mismatch_count++;
          end
          if (bad_escape !== want.bad) begin
            $error("bad_escape: expected %0b, got %0b", want.bad, bad_escape);
            mismatch_count++;
          end
        end
      end
    end
    out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic put(input logic [7:0] c, input logic fin);
    char_q.push_back('{ch: c, fin: fin});
    chars_pushed++;
  endtask

  function automatic void stage(input logic [7:0] c);
    string_buf.push_back('{ch: c, fin: 1'b0});
  endfunction

  // one string built from plain chars, escapes, runs and noise
  task automatic queue_random_string();
    int         parts;
    int         kind;
    int         v;
    logic [7:0] c;
    char_req_t  nxt;
    parts = $urandom_range(1, 6);
    for (int p = 0; p < parts; p++) begin
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
        do begin
          c = 8'($urandom_range(0, 255));
        end while (c == CHR_BACKSLASH);
        stage(c);
      end else if (kind < 48) begin
        stage(CHR_BACKSLASH);
        case ($urandom_range(0, 8))
          0: stage(CHR_A);
          1: stage(CHR_B);
          2: stage(CHR_F);
          3: stage(CHR_R);
          4: stage(CHR_N);
          5: stage(CHR_T);
          6: stage(CHR_V);
          7: stage(CHR_QUOTE);
          default: stage(CHR_BACKSLASH);
        endcase
      end else if (kind < 64) begin
        stage(CHR_BACKSLASH);
        stage(CHR_X);
        repeat ($urandom_range(0, 4)) begin
          v = $urandom_range(0, 15);
          if (v < 10) stage(CH_ZERO + 8'(v));
          else stage(($urandom_range(1) ? CH_UPPER_A : CHR_A) + 8'(v - 10));
        end
      end else if (kind < 80) begin
        stage(CHR_BACKSLASH);
        repeat ($urandom_range(1, 3)) stage(CH_ZERO + 8'($urandom_range(0, 7)));
      end else if (kind < 88) begin
        stage(CHR_BACKSLASH);
        do begin
          c = 8'($urandom_range(0, 255));
        end while (c == CHR_A || c == CHR_B || c == CHR_F || c == CHR_R || c == CHR_N ||
                   c == CHR_T || c == CHR_V || c == CHR_QUOTE || c == CHR_BACKSLASH ||
                   c == CHR_X || octal_digit(c));
        stage(c);
      end else begin
        stage(8'($urandom_range(0, 255)));
      end
    end
    // sometimes the string stops inside an escape
    if ($urandom_range(0, 99) < 12) begin
      stage(CHR_BACKSLASH);
      if ($urandom_range(1)) stage(CHR_X);
    end
    string_buf[$].fin = 1'b1;
    while (string_buf.size() != 0) begin
      nxt = string_buf.pop_front();
      put(nxt.ch, nxt.fin);
    end
  endtask

  task automatic wait_drained();
    while (chars_taken != chars_pushed || decoded_q.size() != 0) @(posedge clk);
  endtask

  // stimulus and end of run
  initial begin
    int base;
    logic paused;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // byte extremes
    put(8'h00, 1'b0);
    put(8'hFF, 1'b1);
    // named escape
    put(CHR_BACKSLASH, 1'b0);
    put(CHR_N, 1'b0);
    // hex run with overflow and both letter cases, ended by a non-hex char
    put(CHR_BACKSLASH, 1'b0);
    put(CHR_X, 1'b0);
    put(CH_UPPER_F, 1'b0);
    put(CHR_F, 1'b0);
    put(CH_ZERO + 8'd1, 1'b0);
    put(CHR_A + 8'd6, 1'b0);
    // octal overflow
    put(CHR_BACKSLASH, 1'b0);
    put(CH_SEVEN, 1'b0);
    put(CH_SEVEN, 1'b0);
    put(CH_SEVEN, 1'b0);
    // two-digit octal ended by 8
    put(CHR_BACKSLASH, 1'b0);
    put(CH_ZERO + 8'd1, 1'b0);
    put(CH_ZERO + 8'd2, 1'b0);
    put(CH_ZERO + 8'd8, 1'b0);
    // empty hex run ended by a backslash, then unknown escape 9
    put(CHR_BACKSLASH, 1'b0);
    put(CHR_X, 1'b0);
    put(CHR_BACKSLASH, 1'b0);
    put(CH_NINE, 1'b0);
    // dangling backslash
    put(CHR_BACKSLASH, 1'b1);
    // string ends on the x
    put(CHR_BACKSLASH, 1'b0);
    put(CHR_X, 1'b1);
    // string end flushes an octal run
    put(CHR_BACKSLASH, 1'b0);
    put(CH_ZERO + 8'd5, 1'b1);

    wait_drained();

    base = chars_pushed;
    while (chars_pushed - base < RANDOM_CHARS) begin
      queue_random_string();
      if (!paused && chars_pushed - base >= RANDOM_CHARS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
